// File: sv/drpfe_pkg.sv
// ----------------------------------------------------------------------------
// drpfe_pkg
// types, codes and constants shared by the dimmer pulse frame encoder
// ----------------------------------------------------------------------------
package drpfe_pkg;

    // field widths
    localparam int ID_W     = 26;
    localparam int UNIT_W   = 5;
    localparam int MODE_W   = 2;
    localparam int LEVEL_W  = 5;
    localparam int BASE_W   = 10;
    localparam int FACTOR_W = 6;
    localparam int PULSE_W  = 16;
    localparam int COUNT_W  = 3;
    localparam int ERR_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // input field positions in s_tdata
    localparam int ID_LSB    = 0;
    localparam int UNIT_LSB  = ID_LSB + ID_W;
    localparam int ALL_LSB   = UNIT_LSB + UNIT_W;
    localparam int MODE_LSB  = ALL_LSB + 1;
    localparam int LEVEL_LSB = MODE_LSB + MODE_W;

    // frame payload
    localparam int WORD_W = 36;
    localparam int CNT_W  = 6;
    localparam logic [CNT_W-1:0] BIT_CNT_FIRST = CNT_W'(WORD_W - 1);
    // bit counter value while the state slot goes out
    localparam logic [CNT_W-1:0] STATE_SLOT_CNT = CNT_W'(8);

    localparam logic [COUNT_W-1:0] CNT_PAIR  = 3'd2;
    localparam logic [COUNT_W-1:0] CNT_QUAD  = 3'd4;
    localparam logic [COUNT_W-1:0] CNT_NONE  = 3'd0;

    // register reset values
    localparam logic [BASE_W-1:0]   BASE_RST   = 10'd300;
    localparam logic [FACTOR_W-1:0] LONG_RST   = 6'd5;
    localparam logic [FACTOR_W-1:0] HEADER_RST = 6'd10;
    localparam logic [FACTOR_W-1:0] FOOTER_RST = 6'd38;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_LONG   = 2'd1,
        CFG_HEADER = 2'd2,
        CFG_FOOTER = 2'd3
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF = 2'd0,
        MODE_ON  = 2'd1,
        MODE_DIM = 2'd2,
        MODE_BAD = 2'd3
    } mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 3'd0,
        ERR_ID    = 3'd1,
        ERR_UNIT  = 3'd2,
        ERR_LEVEL = 3'd3,
        ERR_MODE  = 3'd4
    } err_t;

    // microcode
    typedef logic [2:0] step_t;

    localparam step_t ST_WAIT = 3'd0;
    localparam step_t ST_MULL = 3'd1;
    localparam step_t ST_MULH = 3'd2;
    localparam step_t ST_HDR  = 3'd3;
    localparam step_t ST_BIT  = 3'd4;
    localparam step_t ST_FTR  = 3'd5;
    localparam step_t ST_ERR  = 3'd6;
    localparam step_t ST_SPARE = 3'd7;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_LONG = 2'd1,
        MUL_HDR  = 2'd2,
        MUL_FTR  = 2'd3
    } mul_sel_t;

    typedef enum logic [2:0] {
        EMIT_NONE = 3'd0,
        EMIT_HDR  = 3'd1,
        EMIT_BIT  = 3'd2,
        EMIT_FTR  = 3'd3,
        EMIT_ERR  = 3'd4
    } emit_t;

    typedef enum logic [1:0] {
        JMP_NEXT   = 2'd0,
        JMP_ALWAYS = 2'd1,
        JMP_ERR    = 2'd2,
        JMP_MORE   = 2'd3
    } jmp_t;

    typedef struct packed {
        logic     take;
        mul_sel_t mul;
        emit_t    emit;
        jmp_t     jmp;
        step_t    target;
    } uword_t;

    typedef struct packed {
        logic     fire;
        logic     take;
        mul_sel_t mul;
        emit_t    emit;
    } ctl_t;

    typedef struct packed {
        logic cmd_err;
        logic bits_left;
        logic out_free;
    } stat_t;

endpackage

// File: sv/dimmer_remote_pulse_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// dimmer_remote_pulse_frame_encoder_unit
// microcoded encoder from dimmer commands to ook pulse groups
// ----------------------------------------------------------------------------
// Each accepted command is checked and then turned into 38 pulse-group
// transactions (header pair, 36 four-pulse bit groups MSB first, footer pair
// with tlast), or into a single error transaction with tlast set. A short
// program in a control store steps through the work: one step takes the
// command, the next two steps and the header step run the shared 10x6 pulse
// multiplier, then one group leaves per cycle while m_tready is high. The next
// command is taken only when the program returns to its wait step. Pulse
// lengths scale with the registers base_pulse, long_factor, header_factor and
// footer_factor, which the user must write only while the block is idle; the
// block itself does not enforce this.
module dimmer_remote_pulse_frame_encoder_unit
    import drpfe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BASE_W-1:0]     cfg_wdata,
    // command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // id, unit, all, mode, dimlevel, pad
    // pulse group stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // pulse_a, pulse_b, pulse_c, pulse_d,
                                             // pulse_count, error, pad
    output logic                  m_tlast
);

    ctl_t  ctl;
    stat_t stat;

    drpfe_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .ctl      (ctl)
    );

    drpfe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .ctl       (ctl),
        .stat      (stat)
    );

    assign s_tready = ctl.take && aresetn;

endmodule

// File: sv/drpfe_urom.sv
// ----------------------------------------------------------------------------
// drpfe_urom
// control store: one control word per program step
// ----------------------------------------------------------------------------
module drpfe_urom
    import drpfe_pkg::*;
(
    input  step_t  step,
    output uword_t uword
);

    always_comb begin
        unique case (step)
            ST_WAIT: uword = '{take: 1'b1, mul: MUL_NONE, emit: EMIT_NONE,
                               jmp: JMP_NEXT, target: ST_WAIT};
            ST_MULL: uword = '{take: 1'b0, mul: MUL_LONG, emit: EMIT_NONE,
                               jmp: JMP_ERR, target: ST_ERR};
            ST_MULH: uword = '{take: 1'b0, mul: MUL_HDR, emit: EMIT_NONE,
                               jmp: JMP_NEXT, target: ST_WAIT};
            ST_HDR:  uword = '{take: 1'b0, mul: MUL_FTR, emit: EMIT_HDR,
                               jmp: JMP_NEXT, target: ST_WAIT};
            ST_BIT:  uword = '{take: 1'b0, mul: MUL_NONE, emit: EMIT_BIT,
                               jmp: JMP_MORE, target: ST_BIT};
            ST_FTR:  uword = '{take: 1'b0, mul: MUL_NONE, emit: EMIT_FTR,
                               jmp: JMP_ALWAYS, target: ST_WAIT};
            ST_ERR:  uword = '{take: 1'b0, mul: MUL_NONE, emit: EMIT_ERR,
                               jmp: JMP_ALWAYS, target: ST_WAIT};
            default: uword = '{take: 1'b0, mul: MUL_NONE, emit: EMIT_NONE,
                               jmp: JMP_ALWAYS, target: ST_WAIT};
        endcase
    end

endmodule

// File: sv/drpfe_seq.sv
// ----------------------------------------------------------------------------
// drpfe_seq
// step counter with conditional jumps and stall on either handshake
// ----------------------------------------------------------------------------
module drpfe_seq
    import drpfe_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  stat_t stat,
    output ctl_t  ctl
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uword;
    logic   stall;

    drpfe_urom u_urom (
        .step  (step_reg),
        .uword (uword)
    );

    assign stall = (uword.take && !s_tvalid) ||
                   ((uword.emit != EMIT_NONE) && !stat.out_free);

    assign ctl.fire = !stall;
    assign ctl.take = uword.take;
    assign ctl.mul  = uword.mul;
    assign ctl.emit = uword.emit;

    always_comb begin
        step_next = step_reg;
        if (!stall) begin
            unique case (uword.jmp)
                JMP_NEXT:   step_next = step_reg + 3'd1;
                JMP_ALWAYS: step_next = uword.target;
                JMP_ERR:    step_next = stat.cmd_err ? uword.target : step_reg + 3'd1;
                JMP_MORE:   step_next = stat.bits_left ? uword.target : step_reg + 3'd1;
                default:    step_next = ST_WAIT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// File: sv/drpfe_dp.sv
// ----------------------------------------------------------------------------
// drpfe_dp
// command check, pulse length multiplier, bit shifter and output register
// ----------------------------------------------------------------------------
module drpfe_dp
    import drpfe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BASE_W-1:0]     cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tlast,
    input  ctl_t                  ctl,
    output stat_t                 stat
);

    logic [BASE_W-1:0]   base_reg;
    logic [FACTOR_W-1:0] long_f_reg;
    logic [FACTOR_W-1:0] hdr_f_reg;
    logic [FACTOR_W-1:0] ftr_f_reg;

    logic [ID_W-1:0]    in_id;
    logic [UNIT_W-1:0]  in_unit;
    logic               in_all;
    mode_t              in_mode;
    logic [LEVEL_W-1:0] in_level;
    err_t               in_err;
    logic [WORD_W-1:0]  in_word;

    err_t               err_reg;
    logic               dim_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [FACTOR_W-1:0] mul_factor;
    logic [PULSE_W-1:0]  mul_prod;
    logic [PULSE_W-1:0]  long_reg;
    logic [PULSE_W-1:0]  hdr_reg;
    logic [PULSE_W-1:0]  ftr_reg;

    logic [PULSE_W-1:0]  short_p;
    logic                out_load;
    logic                slot_state;
    logic [PULSE_W-1:0]  a_next, b_next, c_next, d_next;
    logic [COUNT_W-1:0]  cnt_out_next;
    err_t                err_out_next;
    logic                last_next;

    logic [PULSE_W-1:0]  a_reg, b_reg, c_reg, d_reg;
    logic [COUNT_W-1:0]  cnt_out_reg;
    err_t                err_out_reg;
    logic                last_reg;
    logic                valid_reg;
    logic                valid_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= BASE_RST;
            long_f_reg <= LONG_RST;
            hdr_f_reg  <= HEADER_RST;
            ftr_f_reg  <= FOOTER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE:   base_reg   <= cfg_wdata;
                CFG_LONG:   long_f_reg <= cfg_wdata[FACTOR_W-1:0];
                CFG_HEADER: hdr_f_reg  <= cfg_wdata[FACTOR_W-1:0];
                CFG_FOOTER: ftr_f_reg  <= cfg_wdata[FACTOR_W-1:0];
                default:    ;
            endcase
        end
    end

    // command unpack and check
    assign in_id    = s_tdata[ID_LSB +: ID_W];
    assign in_unit  = s_tdata[UNIT_LSB +: UNIT_W];
    assign in_all   = s_tdata[ALL_LSB];
    assign in_mode  = mode_t'(s_tdata[MODE_LSB +: MODE_W]);
    assign in_level = s_tdata[LEVEL_LSB +: LEVEL_W];

    always_comb begin
        if (in_mode == MODE_BAD) begin
            in_err = ERR_MODE;
        end else if (in_id == '0) begin
            in_err = ERR_ID;
        end else if (!in_all && in_unit[UNIT_W-1]) begin
            in_err = ERR_UNIT;
        end else if ((in_mode == MODE_DIM) && in_level[LEVEL_W-1]) begin
            in_err = ERR_LEVEL;
        end else begin
            in_err = ERR_NONE;
        end
    end

    assign in_word = {in_id, in_all, (in_mode == MODE_ON),
                      (in_all ? 4'b0000 : in_unit[3:0]),
                      ((in_mode == MODE_DIM) ? in_level[3:0] : 4'b0000)};

    always_ff @(posedge aclk) begin
        if (ctl.fire && ctl.take) begin
            err_reg  <= in_err;
            dim_reg  <= (in_mode == MODE_DIM);
            word_reg <= in_word;
        end else if (ctl.fire && (ctl.emit == EMIT_BIT)) begin
            word_reg <= {word_reg[WORD_W-2:0], 1'b0};
        end
        if (ctl.fire && (ctl.emit == EMIT_HDR)) begin
            cnt_reg <= BIT_CNT_FIRST;
        end else if (ctl.fire && (ctl.emit == EMIT_BIT)) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // shared multiplier
    always_comb begin
        case (ctl.mul)
            MUL_LONG: mul_factor = long_f_reg;
            MUL_HDR:  mul_factor = hdr_f_reg;
            MUL_FTR:  mul_factor = ftr_f_reg;
            default:  mul_factor = '0;
        endcase
    end

    assign mul_prod = PULSE_W'(base_reg) * PULSE_W'(mul_factor);

    always_ff @(posedge aclk) begin
        if (ctl.fire) begin
            case (ctl.mul)
                MUL_LONG: long_reg <= mul_prod;
                MUL_HDR:  hdr_reg  <= mul_prod;
                MUL_FTR:  ftr_reg  <= mul_prod;
                default:  ;
            endcase
        end
    end

    // group build
    assign short_p    = PULSE_W'(base_reg);
    assign slot_state = dim_reg && (cnt_reg == STATE_SLOT_CNT);

    always_comb begin
        a_next       = short_p;
        b_next       = short_p;
        c_next       = '0;
        d_next       = '0;
        cnt_out_next = CNT_PAIR;
        err_out_next = ERR_NONE;
        last_next    = 1'b0;
        case (ctl.emit)
            EMIT_HDR: begin
                b_next = hdr_reg;
            end
            EMIT_BIT: begin
                cnt_out_next = CNT_QUAD;
                c_next       = short_p;
                if (slot_state) begin
                    d_next = short_p;
                end else if (word_reg[WORD_W-1]) begin
                    b_next = long_reg;
                    d_next = short_p;
                end else begin
                    d_next = long_reg;
                end
            end
            EMIT_FTR: begin
                b_next    = ftr_reg;
                last_next = 1'b1;
            end
            EMIT_ERR: begin
                a_next       = '0;
                b_next       = '0;
                cnt_out_next = CNT_NONE;
                err_out_next = err_reg;
                last_next    = 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    assign stat.out_free  = !valid_reg || m_tready;
    assign stat.cmd_err   = (err_reg != ERR_NONE);
    assign stat.bits_left = (cnt_reg != '0);

    assign out_load   = ctl.fire && (ctl.emit != EMIT_NONE);
    assign valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            d_reg       <= d_next;
            cnt_out_reg <= cnt_out_next;
            err_out_reg <= err_out_next;
            last_reg    <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, err_out_reg, cnt_out_reg, d_reg, c_reg, b_reg, a_reg};

endmodule
